// ----- rtl/page_framebuffer_draw_engine_unit_assert.svh -----
// Assertion macros shared by the draw engine RTL.
`ifndef PAGE_FRAMEBUFFER_DRAW_ENGINE_UNIT_ASSERT_SVH
`define PAGE_FRAMEBUFFER_DRAW_ENGINE_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
// Checks a property on every rising edge of clk_i outside of reset.
`define PFDE_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("pfde assertion failed");
// Checks that a condition never holds.
`define PFDE_NEVER(label, expr) `PFDE_ASSERT(label, !(expr))
`else
`define PFDE_ASSERT(label, prop)
`define PFDE_NEVER(label, expr)
`endif
`endif

// ----- rtl/pfde_pkg.sv -----
// Package with screen geometry, opcodes and addressing helpers of the draw engine.
`default_nettype none
package pfde_pkg;

  localparam int SCREEN_WIDTH  = 128;
  localparam int SCREEN_HEIGHT = 64;
  localparam int PAGES         = (SCREEN_HEIGHT + 7) / 8;
  localparam int STORE_DEPTH   = SCREEN_WIDTH * PAGES;
  localparam int AW            = $clog2(STORE_DEPTH);
  localparam int PW            = (PAGES > 1) ? $clog2(PAGES) : 1;
  // Width of the row group of an 8-bit y coordinate (y / 8).
  localparam int QW            = 5;

  localparam logic [2:0] OP_POINT     = 3'd0;
  localparam logic [2:0] OP_RECT      = 3'd1;
  localparam logic [2:0] OP_CLEAR     = 3'd2;
  localparam logic [2:0] OP_BMP_START = 3'd3;
  localparam logic [2:0] OP_BMP_BYTE  = 3'd4;
  localparam logic [2:0] OP_READ      = 3'd5;

  // Bytes are stored column-major: column * PAGES + page.
  function automatic logic [AW-1:0] byte_addr(logic [7:0] col, logic [PW-1:0] page);
    return AW'(32'(col) * PAGES + 32'(page));
  endfunction

  // Page that holds row group q; the top rows live in the last page.
  function automatic logic [PW-1:0] page_of(logic [QW-1:0] q);
    return PW'(PAGES - 1 - 32'(q));
  endfunction

endpackage
`default_nettype wire

// ----- rtl/pfde_if.sv -----
// Valid/ready channel interfaces for draw commands and read results.
`default_nettype none
interface pfde_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] opcode;
  logic [7:0] x_a;
  logic [7:0] y_a;
  logic [7:0] x_b;
  logic [7:0] y_b;
  logic [7:0] data;

  modport source (output valid, opcode, x_a, y_a, x_b, y_b, data, input ready);
  modport sink   (input valid, opcode, x_a, y_a, x_b, y_b, data, output ready);
endinterface

interface pfde_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;

  modport source (output valid, read_data, input ready);
  modport sink   (input valid, read_data, output ready);
endinterface
`default_nettype wire

// ----- rtl/pfde_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none
module pfde_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

// ----- rtl/page_framebuffer_draw_engine_unit.sv -----
// Top level of the monochrome page framebuffer draw engine.
//
// Commands arrive as beats on cmd_i; each beat is one drawing command (point, filled
// rectangle, whole-store fill, bitmap start, bitmap byte, byte read). Only a read
// produces a result beat on rsp_o, carrying the stored byte (zero when out of range).
// The framebuffer lives in one synchronous RAM of SCREEN_WIDTH * PAGES bytes, stored
// column-major. Every drawing step but the whole-store fill is a read-modify-write of
// one byte: the read is issued in one cycle and the merged byte is written in the next.
// Throughput is set by that RAM port: a rectangle reads and writes each byte it covers
// in turn, a bitmap byte steps over each skipped bit and reads and writes each drawn
// bit, and a whole-store fill writes one byte per cycle.
// A read passes through S_RD_ISSUE, where it waits until the result register is
// free, and S_RD_CAP, which loads the result beat.
// After reset a clearing pass writes zero to every byte; cmd_i.ready stays low until
// it ends.
// The result register is a separate stage: while rsp_o is stalled the engine keeps
// drawing and only holds a further read until the waiting result has been taken.
// cmd_i.ready is high whenever the engine is idle.
`default_nettype none
`include "page_framebuffer_draw_engine_unit_assert.svh"
module page_framebuffer_draw_engine_unit (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  pfde_cmd_if.sink   cmd_i,
  pfde_rsp_if.source rsp_o
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_FILL     = 3'd1;
  localparam logic [2:0] S_WR       = 3'd2;
  localparam logic [2:0] S_RECT     = 3'd3;
  localparam logic [2:0] S_BMP      = 3'd4;
  localparam logic [2:0] S_RD_ISSUE = 3'd5;
  localparam logic [2:0] S_RD_CAP   = 3'd6;

  // What a finished write returns to.
  localparam logic [1:0] MODE_PT   = 2'd0;
  localparam logic [1:0] MODE_RECT = 2'd1;
  localparam logic [1:0] MODE_BMP  = 2'd2;

  localparam logic [pfde_pkg::AW-1:0] FILL_LAST = pfde_pkg::AW'(pfde_pkg::STORE_DEPTH - 1);
  localparam logic [7:0] X_MAX = 8'(pfde_pkg::SCREEN_WIDTH - 1);
  localparam logic [7:0] Y_MAX = 8'(pfde_pkg::SCREEN_HEIGHT - 1);

  // Control state.
  logic [2:0]              state_q, state_d;
  logic [1:0]              mode_q, mode_d;
  logic [pfde_pkg::AW-1:0] fill_cnt_q, fill_cnt_d;
  logic [7:0]              fill_byte_q, fill_byte_d;
  logic [2:0]              bb_q, bb_d;
  logic                    out_valid_q, out_valid_d;
  logic [7:0]              bmp_ox_q, bmp_ox_d;
  logic [7:0]              bmp_oy_q, bmp_oy_d;
  logic [7:0]              bmp_w_q, bmp_w_d;
  logic [7:0]              bmp_h_q, bmp_h_d;
  logic [5:0]              col_q, col_d;
  logic [7:0]              row_q, row_d;

  // Payload of the command in flight.
  logic [pfde_pkg::AW-1:0] addr_q, addr_d;
  logic [7:0]              mask_q, mask_d;
  logic                    val_q, val_d;
  logic [7:0]              rx_q, rx_d;
  logic [7:0]              rx_end_q, rx_end_d;
  logic [pfde_pkg::QW-1:0] rq_q, rq_d;
  logic [pfde_pkg::QW-1:0] rq_start_q, rq_start_d;
  logic [pfde_pkg::QW-1:0] rq_end_q, rq_end_d;
  logic [2:0]              ylo_q, ylo_d;
  logic [2:0]              yhi_q, yhi_d;
  logic [7:0]              bx_q, bx_d;
  logic [7:0]              by_q, by_d;
  logic [7:0]              dmask_q, dmask_d;
  logic                    rd_ok_q, rd_ok_d;
  logic [7:0]              out_data_q, out_data_d;

  // RAM port.
  logic                    ram_we;
  logic [pfde_pkg::AW-1:0] ram_waddr;
  logic [7:0]              ram_wdata;
  logic [pfde_pkg::AW-1:0] ram_raddr;
  logic [7:0]              ram_rdata;

  logic                    cmd_acc;
  logic                    rsp_acc;
  logic                    slot_free;
  logic                    pt_on;
  logic [pfde_pkg::AW-1:0] pt_addr;
  logic                    rect_ok;
  logic [7:0]              rect_x_end;
  logic [7:0]              rect_y_end;
  logic [2:0]              r_lo;
  logic [2:0]              r_hi;
  logic [7:0]              r_mask;
  logic [pfde_pkg::AW-1:0] rect_addr;
  logic [7:0]              bmp_dm;
  logic [7:0]              bmp_new_y;
  logic [5:0]              byte_width;
  logic [7:0]              bmp_x;
  logic                    bmp_draw;
  logic [pfde_pkg::AW-1:0] bmp_addr;
  logic [pfde_pkg::AW-1:0] rd_addr;
  logic                    rd_on;
  logic [7:0]              merged;

  pfde_ram #(
    .WIDTH(8),
    .DEPTH(pfde_pkg::STORE_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign cmd_i.ready     = (state_q == S_IDLE);
  assign cmd_acc         = cmd_i.valid && cmd_i.ready;
  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.read_data = out_data_q;
  assign rsp_acc         = out_valid_q && rsp_o.ready;
  assign slot_free       = !out_valid_q || rsp_o.ready;

  // Point: one byte, one bit.
  assign pt_on   = (32'(cmd_i.x_a) < pfde_pkg::SCREEN_WIDTH) &&
                   (32'(cmd_i.y_a) < pfde_pkg::SCREEN_HEIGHT);
  assign pt_addr = pfde_pkg::byte_addr(cmd_i.x_a, pfde_pkg::page_of(cmd_i.y_a[7:3]));

  // Rectangle setup: reject empty or fully off-screen rectangles, clip the far edges.
  assign rect_ok    = (cmd_i.x_a <= cmd_i.x_b) && (cmd_i.y_a <= cmd_i.y_b) && pt_on;
  assign rect_x_end = (cmd_i.x_b > X_MAX) ? X_MAX : cmd_i.x_b;
  assign rect_y_end = (cmd_i.y_b > Y_MAX) ? Y_MAX : cmd_i.y_b;

  // Bits of the current row group that fall inside the rectangle.
  assign r_lo      = (rq_q == rq_start_q) ? ylo_q : 3'd0;
  assign r_hi      = (rq_q == rq_end_q) ? yhi_q : 3'd7;
  assign r_mask    = (8'hFF >> r_lo) & (8'hFF << (3'd7 - r_hi));
  assign rect_addr = pfde_pkg::byte_addr(rx_q, pfde_pkg::page_of(rq_q));

  // Bitmap byte: which of the eight bits draw, given the data and the bitmap width.
  always_comb begin
    for (int b = 0; b < 8; b++) begin
      bmp_dm[b] = cmd_i.data[7-b] && ({col_q, 3'(b)} < {1'b0, bmp_w_q});
    end
  end
  assign bmp_new_y  = 8'(bmp_oy_q + row_q);
  assign byte_width = 6'((9'(bmp_w_q) + 9'd7) >> 3);
  assign bmp_x      = 8'(bx_q + {5'd0, bb_q});
  assign bmp_draw   = dmask_q[bb_q] && (32'(bmp_x) < pfde_pkg::SCREEN_WIDTH);
  assign bmp_addr   = pfde_pkg::byte_addr(bmp_x, pfde_pkg::page_of(by_q[7:3]));

  // Read: the page is given directly.
  assign rd_on   = (32'(cmd_i.x_a) < pfde_pkg::SCREEN_WIDTH) &&
                   (32'(cmd_i.y_a) < pfde_pkg::PAGES);
  assign rd_addr = pfde_pkg::byte_addr(cmd_i.x_a, cmd_i.y_a[pfde_pkg::PW-1:0]);

  assign merged = (ram_rdata & ~mask_q) | (val_q ? mask_q : 8'h00);

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    fill_cnt_d  = fill_cnt_q;
    fill_byte_d = fill_byte_q;
    bb_d        = bb_q;
    out_valid_d = out_valid_q;
    bmp_ox_d    = bmp_ox_q;
    bmp_oy_d    = bmp_oy_q;
    bmp_w_d     = bmp_w_q;
    bmp_h_d     = bmp_h_q;
    col_d       = col_q;
    row_d       = row_q;
    addr_d      = addr_q;
    mask_d      = mask_q;
    val_d       = val_q;
    rx_d        = rx_q;
    rx_end_d    = rx_end_q;
    rq_d        = rq_q;
    rq_start_d  = rq_start_q;
    rq_end_d    = rq_end_q;
    ylo_d       = ylo_q;
    yhi_d       = yhi_q;
    bx_d        = bx_q;
    by_d        = by_q;
    dmask_d     = dmask_q;
    rd_ok_d     = rd_ok_q;
    out_data_d  = out_data_q;
    ram_we      = 1'b0;
    ram_waddr   = addr_q;
    ram_wdata   = merged;
    ram_raddr   = pt_addr;

    if (rsp_acc) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        // The point address is read speculatively, so a point goes straight to its write.
        if (cmd_acc) begin
          case (cmd_i.opcode)
            pfde_pkg::OP_POINT: begin
              if (pt_on) begin
                addr_d  = pt_addr;
                mask_d  = 8'h80 >> cmd_i.y_a[2:0];
                val_d   = cmd_i.data[0];
                mode_d  = MODE_PT;
                state_d = S_WR;
              end
            end
            pfde_pkg::OP_RECT: begin
              if (rect_ok) begin
                rx_d       = cmd_i.x_a;
                rx_end_d   = rect_x_end;
                rq_d       = cmd_i.y_a[7:3];
                rq_start_d = cmd_i.y_a[7:3];
                rq_end_d   = rect_y_end[7:3];
                ylo_d      = cmd_i.y_a[2:0];
                yhi_d      = rect_y_end[2:0];
                val_d      = cmd_i.data[0];
                mode_d     = MODE_RECT;
                state_d    = S_RECT;
              end
            end
            pfde_pkg::OP_CLEAR: begin
              fill_byte_d = cmd_i.data;
              fill_cnt_d  = '0;
              state_d     = S_FILL;
            end
            pfde_pkg::OP_BMP_START: begin
              bmp_ox_d = cmd_i.x_a;
              bmp_oy_d = cmd_i.y_a;
              bmp_w_d  = cmd_i.x_b;
              bmp_h_d  = cmd_i.y_b;
              col_d    = '0;
              row_d    = '0;
            end
            pfde_pkg::OP_BMP_BYTE: begin
              if (row_q < bmp_h_q) begin
                bx_d    = 8'(bmp_ox_q + {col_q[4:0], 3'd0});
                by_d    = bmp_new_y;
                // A row below the screen draws nothing.
                dmask_d = (32'(bmp_new_y) < pfde_pkg::SCREEN_HEIGHT) ? bmp_dm : 8'h00;
                val_d   = 1'b1;
                bb_d    = '0;
                mode_d  = MODE_BMP;
                state_d = S_BMP;
                if (7'(col_q) + 7'd1 >= 7'(byte_width)) begin
                  col_d = '0;
                  row_d = row_q + 8'd1;
                end else begin
                  col_d = col_q + 6'd1;
                end
              end
            end
            pfde_pkg::OP_READ: begin
              addr_d  = rd_addr;
              rd_ok_d = rd_on;
              state_d = S_RD_ISSUE;
            end
            default: begin
            end
          endcase
        end
      end
      S_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = fill_cnt_q;
        ram_wdata = fill_byte_q;
        if (fill_cnt_q == FILL_LAST) begin
          state_d = S_IDLE;
        end else begin
          fill_cnt_d = fill_cnt_q + 1'b1;
        end
      end
      S_WR: begin
        ram_we = 1'b1;
        case (mode_q)
          MODE_RECT: begin
            state_d = S_RECT;
            if (rq_q == rq_end_q) begin
              rq_d = rq_start_q;
              if (rx_q == rx_end_q) begin
                state_d = S_IDLE;
              end else begin
                rx_d = rx_q + 8'd1;
              end
            end else begin
              rq_d = rq_q + 1'b1;
            end
          end
          MODE_BMP: begin
            if (bb_q == 3'd7) begin
              state_d = S_IDLE;
            end else begin
              bb_d    = bb_q + 3'd1;
              state_d = S_BMP;
            end
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end
      S_RECT: begin
        ram_raddr = rect_addr;
        addr_d    = rect_addr;
        mask_d    = r_mask;
        state_d   = S_WR;
      end
      S_BMP: begin
        if (bmp_draw) begin
          ram_raddr = bmp_addr;
          addr_d    = bmp_addr;
          mask_d    = 8'h80 >> by_q[2:0];
          state_d   = S_WR;
        end else if (bb_q == 3'd7) begin
          state_d = S_IDLE;
        end else begin
          bb_d = bb_q + 3'd1;
        end
      end
      S_RD_ISSUE: begin
        // Hold the read until the result register can take the byte.
        ram_raddr = addr_q;
        if (slot_free) begin
          state_d = S_RD_CAP;
        end
      end
      S_RD_CAP: begin
        out_valid_d = 1'b1;
        out_data_d  = rd_ok_q ? ram_rdata : 8'h00;
        state_d     = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_FILL;
      mode_q      <= MODE_PT;
      fill_cnt_q  <= '0;
      fill_byte_q <= '0;
      bb_q        <= '0;
      out_valid_q <= 1'b0;
      bmp_ox_q    <= '0;
      bmp_oy_q    <= '0;
      bmp_w_q     <= '0;
      bmp_h_q     <= '0;
      col_q       <= '0;
      row_q       <= '0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      fill_cnt_q  <= fill_cnt_d;
      fill_byte_q <= fill_byte_d;
      bb_q        <= bb_d;
      out_valid_q <= out_valid_d;
      bmp_ox_q    <= bmp_ox_d;
      bmp_oy_q    <= bmp_oy_d;
      bmp_w_q     <= bmp_w_d;
      bmp_h_q     <= bmp_h_d;
      col_q       <= col_d;
      row_q       <= row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q     <= addr_d;
    mask_q     <= mask_d;
    val_q      <= val_d;
    rx_q       <= rx_d;
    rx_end_q   <= rx_end_d;
    rq_q       <= rq_d;
    rq_start_q <= rq_start_d;
    rq_end_q   <= rq_end_d;
    ylo_q      <= ylo_d;
    yhi_q      <= yhi_d;
    bx_q       <= bx_d;
    by_q       <= by_d;
    dmask_q    <= dmask_d;
    rd_ok_q    <= rd_ok_d;
    out_data_q <= out_data_d;
  end

  // The write-back goes to the byte that was read in the cycle before.
  `PFDE_ASSERT(a_wr_matches_read, (state_q == S_WR) |-> (addr_q == $past(ram_raddr)))
  // A result beat appears only after a read capture.
  `PFDE_ASSERT(a_rsp_from_read, $rose(out_valid_q) |-> ($past(state_q) == S_RD_CAP))
  // A capture never overwrites a result that still waits.
  `PFDE_NEVER(a_no_rsp_overwrite, (state_q == S_RD_CAP) && out_valid_q)

endmodule
`default_nettype wire
